// ----- rtl/isp_pkg.sv -----
// Shared types and constants for the stride prefetcher with self-tuning degree.
// No dependencies; every rtl module but isp_ram imports this package.
`timescale 1ns / 1ps
package isp_pkg;

  localparam int DEG_SLOTS = 9;

  localparam logic ACT_ACCESS = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  localparam logic [24:0] MEASURE_RESET = 25'd4096;
  localparam logic [31:0] HOLD_RESET    = 32'd4194304;
  localparam logic [3:0]  CHECK_RESET   = 4'd10;

  typedef enum logic [1:0] {
    CFG_VIRTUAL,
    CFG_MEASURE,
    CFG_HOLD,
    CFG_CHECK
  } cfg_idx_e;

  typedef struct packed {
    logic        action;
    logic [63:0] instr_addr;
    logic [63:0] data_addr;
    logic [63:0] retired_total;
    logic [63:0] cycle_total;
    logic        queue_ready;
    logic        mshr_below_half;
  } isp_in_t;

  typedef struct packed {
    logic        prefetch_valid;
    logic [63:0] prefetch_addr;
    logic        fill_this_level;
    logic [4:0]  degree_now;
    logic        tuning_mode;
  } isp_out_t;

  typedef struct packed {
    logic        virtual_mode;
    logic [24:0] measure_window;
    logic [31:0] hold_window;
    logic [3:0]  check_interval;
  } isp_cfg_t;

  typedef struct packed {
    logic        start;
    logic [63:0] r1;
    logic [63:0] c1;
    logic [63:0] r2;
    logic [63:0] c2;
  } isp_ratio_req_t;

  typedef struct packed {
    logic done;
    logic greater;
  } isp_ratio_rsp_t;

  function automatic logic [4:0] degree_of(input logic [3:0] slot);
    logic [4:0] d;
    case (slot)
      4'd1:    d = 5'd1;
      4'd2:    d = 5'd2;
      4'd3:    d = 5'd3;
      4'd4:    d = 5'd4;
      4'd5:    d = 5'd6;
      4'd6:    d = 5'd8;
      4'd7:    d = 5'd12;
      4'd8:    d = 5'd16;
      default: d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/isp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module isp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                  wdata_i,
  input  logic                              re_i,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                  rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- rtl/isp_ratio.sv -----
// Multi-cycle compare of r1*c2 against r2*c1 from 32x32 partial products.
// Depends on isp_pkg.
`timescale 1ns / 1ps
module isp_ratio
  import isp_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  isp_ratio_req_t req_i,
  output isp_ratio_rsp_t rsp_o
);
  logic         run_q;
  logic [3:0]   step_q;
  logic [63:0]  r1_q, c1_q, r2_q, c2_q;
  logic [63:0]  prod_q;
  logic [1:0]   sh_q;
  logic         which_q;
  logic         acc_en_q;
  logic [127:0] acc_a_q, acc_b_q;
  logic         done_q, greater_q;

  logic [63:0]  x, y;
  logic [31:0]  xh, yh;
  logic [127:0] addend;

  always_comb begin
    x  = step_q[2] ? r2_q : r1_q;
    y  = step_q[2] ? c1_q : c2_q;
    xh = step_q[0] ? x[63:32] : x[31:0];
    yh = step_q[1] ? y[63:32] : y[31:0];
    addend = {64'd0, prod_q} << {sh_q, 5'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; step_q <= '0; r1_q <= '0; c1_q <= '0; r2_q <= '0; c2_q <= '0;
      prod_q <= '0; sh_q <= '0; which_q <= 1'b0; acc_en_q <= 1'b0;
      acc_a_q <= '0; acc_b_q <= '0; done_q <= 1'b0; greater_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1; step_q <= '0; acc_en_q <= 1'b0;
        r1_q <= req_i.r1; c1_q <= req_i.c1; r2_q <= req_i.r2; c2_q <= req_i.c2;
        acc_a_q <= '0; acc_b_q <= '0;
      end else if (run_q) begin
        // multiply one partial product, accumulate the previous one
        if (acc_en_q) begin
          if (which_q) acc_b_q <= acc_b_q + addend;
          else acc_a_q <= acc_a_q + addend;
        end
        if (step_q < 4'd8) begin
          prod_q   <= xh * yh;
          sh_q     <= {1'b0, step_q[0]} + {1'b0, step_q[1]};
          which_q  <= step_q[2];
          acc_en_q <= 1'b1;
          step_q   <= step_q + 4'd1;
        end else begin
          acc_en_q <= 1'b0;
          step_q   <= 4'd9;
        end
        if (step_q == 4'd9) begin
          run_q     <= 1'b0;
          done_q    <= 1'b1;
          greater_q <= acc_a_q > acc_b_q;
        end
      end
    end
  end

  assign rsp_o = '{done: done_q, greater: greater_q};
endmodule

// ----- rtl/isp_front.sv -----
// Front end: accepts words, works out the table set, queues them for the back end.
// Depends on isp_pkg.
`timescale 1ns / 1ps
module isp_front
  import isp_pkg::*;
#(
  parameter int TABLE_SETS = 256
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  isp_in_t in_i,
  output logic    head_v_o,
  output isp_in_t head_item_o,
  output logic [(TABLE_SETS>1?$clog2(TABLE_SETS):1)-1:0] head_set_o,
  input  logic    pop_i
);
  localparam int  SET_W = (TABLE_SETS > 1) ? $clog2(TABLE_SETS) : 1;
  localparam bit  POW2  = (TABLE_SETS & (TABLE_SETS - 1)) == 0;
  localparam logic [SET_W:0] NSETS = (SET_W + 1)'(TABLE_SETS);

  logic             stage_v_q, done_q;
  isp_in_t          stage_q;
  logic [SET_W:0]   rem_q;
  logic [3:0]       cnt_q;
  isp_in_t          q_item_q [2];
  logic [SET_W-1:0] q_set_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       count_q;

  logic [SET_W:0]   rem_n;
  logic [3:0]       nib;
  logic [SET_W-1:0] set_now;
  logic             push;

  always_comb begin
    nib   = 4'(stage_q.instr_addr >> {~cnt_q, 2'b00});
    rem_n = rem_q;
    for (int k = 3; k >= 0; k--) begin
      rem_n = {rem_n[SET_W-1:0], nib[k]};
      if (rem_n >= NSETS) rem_n = rem_n - NSETS;
    end
    if (TABLE_SETS == 1) set_now = '0;
    else if (POW2) set_now = stage_q.instr_addr[SET_W-1:0];
    else set_now = rem_q[SET_W-1:0];
    push = stage_v_q && done_q && (count_q != 2'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0; done_q <= 1'b0; stage_q <= '0; rem_q <= '0; cnt_q <= '0;
      wr_q <= 1'b0; rd_q <= 1'b0; count_q <= '0;
      q_item_q[0] <= '0; q_item_q[1] <= '0; q_set_q[0] <= '0; q_set_q[1] <= '0;
    end else begin
      if (start && !busy) begin
        stage_v_q <= 1'b1;
        stage_q   <= in_i;
        rem_q     <= '0;
        cnt_q     <= '0;
        done_q    <= (in_i.action == ACT_TICK) || POW2;
      end else if (push) begin
        stage_v_q <= 1'b0;
      end else if (stage_v_q && !done_q) begin
        // reduce four address bits per cycle, top first
        rem_q <= rem_n;
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) done_q <= 1'b1;
      end
      if (push) begin
        q_item_q[wr_q] <= stage_q;
        q_set_q[wr_q]  <= set_now;
        wr_q <= ~wr_q;
      end
      if (pop_i) rd_q <= ~rd_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  assign busy        = stage_v_q;
  assign head_v_o    = count_q != 2'd0;
  assign head_item_o = q_item_q[rd_q];
  assign head_set_o  = q_set_q[rd_q];
endmodule

// ----- rtl/isp_back.sv -----
// Back end: stride table, lookahead issue and degree-tuning controller.
// Depends on isp_pkg, isp_ram and isp_ratio.
`timescale 1ns / 1ps
module isp_back
  import isp_pkg::*;
#(
  parameter int TABLE_SETS = 256,
  parameter int TABLE_WAYS = 4,
  parameter int LINE_BITS  = 6,
  parameter int PAGE_BITS  = 12
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  isp_cfg_t cfg_i,
  input  logic     head_v_i,
  input  isp_in_t  head_item_i,
  input  logic [(TABLE_SETS>1?$clog2(TABLE_SETS):1)-1:0] head_set_i,
  output logic     pop_o,
  output logic     result_valid_o,
  output isp_out_t out_o
);
  localparam int SET_W  = (TABLE_SETS > 1) ? $clog2(TABLE_SETS) : 1;
  localparam int WAY_W  = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
  localparam int LINE_W = 64 - LINE_BITS;

  typedef enum logic [2:0] {ST_CLR, ST_IDLE, ST_ACC, ST_TICK, ST_MUL, ST_DONE} state_e;

  state_e                            state_q;
  logic [SET_W-1:0]                  clr_q;
  isp_in_t                           item_q;
  logic [SET_W-1:0]                  set_q;
  logic                              look_active_q;
  logic [63:0]                       look_addr_q, look_stride_q;
  logic [4:0]                        look_left_q;
  logic [3:0]                        acc_cnt_q, slot_q, best_slot_q;
  logic                              mode_q;
  logic [63:0]                       base_r_q, base_c_q, best_r_q, best_c_q;
  logic [63:0]                       rdiff_q, cdiff_q;
  logic                              pf_v_q, pf_fill_q;
  logic [63:0]                       pf_addr_q;
  logic                              res_v_q;
  isp_out_t                          out_q;

  logic [TABLE_WAYS*64-1:0]     tag_rd, tag_wr, stride_rd, stride_wr;
  logic [TABLE_WAYS*LINE_W-1:0] line_rd, line_wr;
  logic [TABLE_WAYS*WAY_W-1:0]  age_rd, age_wr;
  logic [TABLE_WAYS-1:0]        vrow_rd, vrow_wr, vrow_wdata;

  logic                re, we;
  logic                clearing, v_we;
  logic [SET_W-1:0]    v_waddr;
  isp_ratio_req_t      rreq;
  isp_ratio_rsp_t      rrsp;

  // access path
  logic [LINE_W-1:0]   line;
  logic                hit, found_inv, any_v, start_look;
  logic [WAY_W-1:0]    hit_way, vic, way;
  logic [63:0]         stride;
  logic [WAY_W-1:0]    ages [TABLE_WAYS];
  logic [WAY_W-1:0]    old_age;

  // tick path
  logic [63:0]         next_addr, rdiff, cdiff;
  logic                same_page, cnt_ok;
  logic [3:0]          slot_inc, new_best;

  assign re    = (state_q == ST_IDLE) && head_v_i;
  assign we    = state_q == ST_ACC;
  assign pop_o = re;

  // valid rows are cleared one set per cycle after reset
  assign clearing   = state_q == ST_CLR;
  assign v_we       = clearing || we;
  assign v_waddr    = clearing ? clr_q : set_q;
  assign vrow_wdata = clearing ? '0 : vrow_wr;

  isp_ram #(.WIDTH(TABLE_WAYS*64), .DEPTH(TABLE_SETS)) u_tag (
    .clk_i, .we_i(we), .waddr_i(set_q), .wdata_i(tag_wr),
    .re_i(re), .raddr_i(head_set_i), .rdata_o(tag_rd));
  isp_ram #(.WIDTH(TABLE_WAYS*LINE_W), .DEPTH(TABLE_SETS)) u_line (
    .clk_i, .we_i(we), .waddr_i(set_q), .wdata_i(line_wr),
    .re_i(re), .raddr_i(head_set_i), .rdata_o(line_rd));
  isp_ram #(.WIDTH(TABLE_WAYS*64), .DEPTH(TABLE_SETS)) u_stride (
    .clk_i, .we_i(we), .waddr_i(set_q), .wdata_i(stride_wr),
    .re_i(re), .raddr_i(head_set_i), .rdata_o(stride_rd));
  isp_ram #(.WIDTH(TABLE_WAYS*WAY_W), .DEPTH(TABLE_SETS)) u_age (
    .clk_i, .we_i(we), .waddr_i(set_q), .wdata_i(age_wr),
    .re_i(re), .raddr_i(head_set_i), .rdata_o(age_rd));
  isp_ram #(.WIDTH(TABLE_WAYS), .DEPTH(TABLE_SETS)) u_valid (
    .clk_i, .we_i(v_we), .waddr_i(v_waddr), .wdata_i(vrow_wdata),
    .re_i(re), .raddr_i(head_set_i), .rdata_o(vrow_rd));

  isp_ratio u_ratio (.clk_i, .rst_ni, .req_i(rreq), .rsp_o(rrsp));

  always_comb begin
    line      = item_q.data_addr[63:LINE_BITS];
    hit       = 1'b0;
    hit_way   = '0;
    found_inv = 1'b0;
    vic       = '0;
    any_v     = |vrow_rd;
    for (int w = 0; w < TABLE_WAYS; w++) begin
      if (!hit && vrow_rd[w] && tag_rd[w*64 +: 64] == item_q.instr_addr) begin
        hit = 1'b1; hit_way = WAY_W'(w);
      end
      // a set with no valid way has never been touched: ages are in way order
      ages[w] = any_v ? age_rd[w*WAY_W +: WAY_W] : WAY_W'(w);
    end
    for (int w = 0; w < TABLE_WAYS; w++) begin
      if (!found_inv && !vrow_rd[w]) begin
        found_inv = 1'b1; vic = WAY_W'(w);
      end
    end
    if (!found_inv) begin
      for (int w = 1; w < TABLE_WAYS; w++) begin
        if (ages[w] > ages[vic]) vic = WAY_W'(w);
      end
    end
    way        = hit ? hit_way : vic;
    stride     = {{LINE_BITS{1'b0}}, line} - {{LINE_BITS{1'b0}}, line_rd[hit_way*LINE_W +: LINE_W]};
    start_look = hit && stride != 64'd0 && stride == stride_rd[hit_way*64 +: 64];
    old_age    = ages[way];
    tag_wr     = tag_rd;
    line_wr    = line_rd;
    stride_wr  = stride_rd;
    vrow_wr    = vrow_rd;
    tag_wr[way*64 +: 64]           = item_q.instr_addr;
    line_wr[way*LINE_W +: LINE_W]  = line;
    stride_wr[way*64 +: 64]        = hit ? stride : 64'd0;
    vrow_wr[way]                   = 1'b1;
    for (int w = 0; w < TABLE_WAYS; w++) begin
      age_wr[w*WAY_W +: WAY_W] = (ages[w] < old_age) ? ages[w] + WAY_W'(1) : ages[w];
    end
    age_wr[way*WAY_W +: WAY_W] = '0;

    next_addr = look_addr_q + (look_stride_q << LINE_BITS);
    same_page = next_addr[63:PAGE_BITS] == look_addr_q[63:PAGE_BITS];
    cnt_ok    = acc_cnt_q >= cfg_i.check_interval;
    rdiff     = item_q.retired_total - base_r_q;
    cdiff     = item_q.cycle_total - base_c_q;
    slot_inc  = slot_q + 4'd1;
    new_best  = rrsp.greater ? slot_q : best_slot_q;

    rreq.start = (state_q == ST_TICK) && cnt_ok && !mode_q &&
                 rdiff >= {39'd0, cfg_i.measure_window} && slot_q != 4'd0;
    rreq.r1 = rdiff;
    rreq.c1 = cdiff;
    rreq.r2 = best_r_q;
    rreq.c2 = best_c_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR; clr_q <= '0; item_q <= '0; set_q <= '0;
      look_active_q <= 1'b0; look_addr_q <= '0; look_stride_q <= '0; look_left_q <= '0;
      acc_cnt_q <= '0; slot_q <= '0; best_slot_q <= '0; mode_q <= 1'b0;
      base_r_q <= '0; base_c_q <= '0; best_r_q <= '0; best_c_q <= '0;
      rdiff_q <= '0; cdiff_q <= '0;
      pf_v_q <= 1'b0; pf_fill_q <= 1'b0; pf_addr_q <= '0;
      res_v_q <= 1'b0; out_q <= '0;
    end else begin
      res_v_q <= 1'b0;
      case (state_q)
        ST_CLR: begin
          clr_q <= clr_q + SET_W'(1);
          if (clr_q == SET_W'(TABLE_SETS - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (head_v_i) begin
            item_q    <= head_item_i;
            set_q     <= head_set_i;
            pf_v_q    <= 1'b0;
            pf_addr_q <= '0;
            pf_fill_q <= 1'b0;
            state_q   <= (head_item_i.action == ACT_TICK) ? ST_TICK : ST_ACC;
          end
        end
        ST_ACC: begin
          if (acc_cnt_q != 4'd15) acc_cnt_q <= acc_cnt_q + 4'd1;
          if (start_look) begin
            look_active_q <= 1'b1;
            look_addr_q   <= {line, {LINE_BITS{1'b0}}};
            look_stride_q <= stride;
            look_left_q   <= degree_of(slot_q);
          end
          state_q <= ST_DONE;
        end
        ST_TICK: begin
          if (look_active_q) begin
            if (look_left_q == 5'd0) begin
              look_active_q <= 1'b0;
            end else if (cfg_i.virtual_mode || same_page) begin
              // refused prefetch: hold the lookahead, retry next tick
              if (item_q.queue_ready) begin
                pf_v_q      <= 1'b1;
                pf_addr_q   <= next_addr;
                pf_fill_q   <= item_q.mshr_below_half;
                look_addr_q <= next_addr;
                look_left_q <= look_left_q - 5'd1;
                if (look_left_q == 5'd1) look_active_q <= 1'b0;
              end
            end else begin
              look_active_q <= 1'b0;
            end
          end
          state_q <= ST_DONE;
          if (cnt_ok) begin
            acc_cnt_q <= '0;
            if (!mode_q) begin
              if (rdiff >= {39'd0, cfg_i.measure_window}) begin
                base_r_q <= item_q.retired_total;
                base_c_q <= item_q.cycle_total;
                rdiff_q  <= rdiff;
                cdiff_q  <= cdiff;
                if (slot_q == 4'd0) begin
                  best_r_q    <= rdiff;
                  best_c_q    <= cdiff;
                  best_slot_q <= slot_q;
                  slot_q      <= slot_inc;
                end else begin
                  state_q <= ST_MUL;
                end
              end
            end else if (rdiff >= {32'd0, cfg_i.hold_window}) begin
              base_r_q <= item_q.retired_total;
              base_c_q <= item_q.cycle_total;
              slot_q   <= '0;
              mode_q   <= 1'b0;
            end
          end
        end
        ST_MUL: begin
          if (rrsp.done) begin
            if (rrsp.greater) begin
              best_r_q    <= rdiff_q;
              best_c_q    <= cdiff_q;
              best_slot_q <= slot_q;
            end
            if (slot_inc == 4'(DEG_SLOTS)) begin
              slot_q <= new_best;
              mode_q <= 1'b1;
            end else begin
              slot_q <= slot_inc;
            end
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          res_v_q <= 1'b1;
          out_q   <= '{prefetch_valid: pf_v_q, prefetch_addr: pf_addr_q,
                       fill_this_level: pf_fill_q, degree_now: degree_of(slot_q),
                       tuning_mode: mode_q};
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_valid_o = res_v_q;
  assign out_o          = out_q;

`ifndef SYNTHESIS
  a_strobe_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q |-> $past(state_q == ST_DONE))
    else $error("result strobe without a finished item");
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q < 4'(DEG_SLOTS))
    else $error("degree slot out of range");
  a_mul_measuring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |-> !mode_q)
    else $error("ratio compare while holding");
`endif
endmodule

// ----- rtl/ip_stride_prefetcher_adaptive_degree.sv -----
// From start to result strobe, an access or a tick passes the front queue and the back end's steps;
// a measuring tick that compares IPC also waits for the ratio compare, and a non-power-of-two
// set count adds set reduction to an access. The back end takes each word through table read,
// update and result; the front takes the next word meanwhile.
// Reset: asynchronous active low; clears lookahead and controller, then the back end clears
// the table valid rows of every set before it takes the first queued word.
// Results are single-cycle strobes; the receiver cannot stall.
`timescale 1ns / 1ps
module ip_stride_prefetcher_adaptive_degree
  import isp_pkg::*;
#(
  parameter int TABLE_SETS = 256,
  parameter int TABLE_WAYS = 4,
  parameter int LINE_BITS  = 6,
  parameter int PAGE_BITS  = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  isp_in_t     in_i,
  output logic        result_valid_o,
  output isp_out_t    out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  localparam int SET_W = (TABLE_SETS > 1) ? $clog2(TABLE_SETS) : 1;

  isp_cfg_t         cfg_q;
  logic             head_v, pop;
  isp_in_t          head_item;
  logic [SET_W-1:0] head_set;

  // config writes land at once; the port never stalls
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{virtual_mode: 1'b0, measure_window: MEASURE_RESET,
                 hold_window: HOLD_RESET, check_interval: CHECK_RESET};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_VIRTUAL: cfg_q.virtual_mode   <= cfg_data_i[0];
        CFG_MEASURE: cfg_q.measure_window <= cfg_data_i[24:0];
        CFG_HOLD:    cfg_q.hold_window    <= cfg_data_i;
        CFG_CHECK:   cfg_q.check_interval <= cfg_data_i[3:0];
        default:     cfg_q <= cfg_q;
      endcase
    end
  end

  // front: take the word, find its set, queue it
  isp_front #(.TABLE_SETS(TABLE_SETS)) u_front (
    .clk_i, .rst_ni, .start, .busy, .in_i,
    .head_v_o(head_v), .head_item_o(head_item), .head_set_o(head_set), .pop_i(pop)
  );

  // back: table update, lookahead issue, degree tuning, result strobe
  isp_back #(
    .TABLE_SETS(TABLE_SETS), .TABLE_WAYS(TABLE_WAYS),
    .LINE_BITS(LINE_BITS), .PAGE_BITS(PAGE_BITS)
  ) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .head_v_i(head_v), .head_item_i(head_item), .head_set_i(head_set), .pop_o(pop),
    .result_valid_o, .out_o
  );
endmodule
